// ----- sv/mar_pkg.sv -----
// Package for the minimum-area rectangle finder: sizes, point and beat types.
// Used by mar_area_mul and min_area_axis_rectangle; no dependencies.
package mar_pkg;

  localparam int unsigned MAX_POINTS = 512;
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned AREA_BITS  = 2 * COORD_BITS;
  localparam int unsigned IDX_W      = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = IDX_W + 1;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } point_t;

  typedef struct packed {
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic        last_point;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] min_area;
    logic        overflowed;
  } out_beat_t;

endpackage

// ----- sv/min_area_axis_rectangle.sv -----
// Minimum-area axis-aligned rectangle finder, top level.
// Depends on mar_pkg and mar_area_mul; holds the point store and the search sequencer.
//
// Points load at one beat per cycle while the input is not stalled, into a 512-entry
// store (extra points are dropped and flagged). The beat marked last_point starts the
// search and the block stalls its input until the result is registered. The search
// walks every pair (i, j), i < j; a pair whose points differ in both axes goes to the
// multiplier, and a pair whose area beats the best so far costs one more pass over
// the store, looking for the two missing corners. The search is bounded by the single
// read port of the store and the one shared multiplier. The result beat is held in an
// output register, and loading of the next set may start while it waits.
module min_area_axis_rectangle (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mar_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mar_pkg::out_beat_t out_data_o
);
  import mar_pkg::*;

  localparam logic [3:0] ST_LOAD  = 4'd0;
  localparam logic [3:0] ST_I_RD  = 4'd1;
  localparam logic [3:0] ST_I_LAT = 4'd2;
  localparam logic [3:0] ST_J_RD  = 4'd3;
  localparam logic [3:0] ST_J_LAT = 4'd4;
  localparam logic [3:0] ST_MUL   = 4'd5;
  localparam logic [3:0] ST_CMP   = 4'd6;
  localparam logic [3:0] ST_SCAN  = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  localparam logic [AREA_BITS-1:0] NO_AREA = '1;

  logic [3:0]           state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 ovf_q, ovf_d;
  logic [AREA_BITS-1:0] best_q, best_d;
  logic [CNT_W-1:0]     i_q, i_d, j_q, j_d, k_q, k_d;
  logic                 sv_q, sv_d;
  logic                 hit_a_q, hit_a_d, hit_b_q, hit_b_d;
  point_t               p1_q, p1_d, p2_q, p2_d;
  logic                 out_valid_q, out_valid_d;
  out_beat_t            out_q, out_d;

  logic                 in_fire;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  point_t               wr_data;
  logic [IDX_W-1:0]     rd_addr;
  point_t               rd_q;
  logic [AREA_BITS-1:0] area;
  logic                 match_a, match_b;

  point_t pt_mem [MAX_POINTS];

  assign in_stall_o = (state_q != ST_LOAD);
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pt_mem[wr_addr] <= wr_data;
    end
    rd_q <= pt_mem[rd_addr];
  end

  mar_area_mul u_area (
    .clk_i  (clk_i),
    .a_i    (p1_q),
    .b_i    (p2_q),
    .area_o (area)
  );

  assign match_a = (rd_q.x == p1_q.x) && (rd_q.y == p2_q.y);
  assign match_b = (rd_q.x == p2_q.x) && (rd_q.y == p1_q.y);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    best_d      = best_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    sv_d        = 1'b0;
    hit_a_d     = hit_a_q;
    hit_b_d     = hit_b_q;
    p1_d        = p1_q;
    p2_d        = p2_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    wr_en       = 1'b0;
    wr_addr     = count_q[IDX_W-1:0];
    wr_data.x   = in_data_i.point_x[COORD_BITS-1:0];
    wr_data.y   = in_data_i.point_y[COORD_BITS-1:0];
    rd_addr     = i_q[IDX_W-1:0];

    case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (count_q < CNT_W'(MAX_POINTS)) begin
            wr_en   = 1'b1;
            count_d = count_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.last_point) begin
            best_d  = NO_AREA;
            i_d     = '0;
            state_d = ST_I_RD;
          end
        end
      end
      ST_I_RD: begin
        rd_addr = i_q[IDX_W-1:0];
        if ((i_q + CNT_W'(1)) >= count_q) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_I_LAT;
        end
      end
      ST_I_LAT: begin
        p1_d    = rd_q;
        j_d     = i_q + CNT_W'(1);
        state_d = ST_J_RD;
      end
      ST_J_RD: begin
        rd_addr = j_q[IDX_W-1:0];
        if (j_q >= count_q) begin
          i_d     = i_q + CNT_W'(1);
          state_d = ST_I_RD;
        end else begin
          state_d = ST_J_LAT;
        end
      end
      ST_J_LAT: begin
        p2_d = rd_q;
        if ((rd_q.x != p1_q.x) && (rd_q.y != p1_q.y)) begin
          state_d = ST_MUL;
        end else begin
          j_d     = j_q + CNT_W'(1);
          state_d = ST_J_RD;
        end
      end
      ST_MUL: begin
        // area unit registers |dx|*|dy| of p1/p2 this cycle
        state_d = ST_CMP;
      end
      ST_CMP: begin
        // only pay for a corner scan when the area would improve
        if (area < best_q) begin
          k_d     = '0;
          hit_a_d = 1'b0;
          hit_b_d = 1'b0;
          state_d = ST_SCAN;
        end else begin
          j_d     = j_q + CNT_W'(1);
          state_d = ST_J_RD;
        end
      end
      ST_SCAN: begin
        // streaming read: sv_q marks rd_q as holding entry k_q - 1
        rd_addr = k_q[IDX_W-1:0];
        if (sv_q) begin
          hit_a_d = hit_a_q || match_a;
          hit_b_d = hit_b_q || match_b;
        end
        if ((hit_a_q && hit_b_q) || ((k_q >= count_q) && !sv_q)) begin
          if (hit_a_q && hit_b_q) begin
            best_d = area;
          end
          j_d     = j_q + CNT_W'(1);
          state_d = ST_J_RD;
        end else if (k_q < count_q) begin
          sv_d = 1'b1;
          k_d  = k_q + CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d         = 1'b1;
          out_d.min_area      = (best_q == NO_AREA) ? '0 : best_q;
          out_d.overflowed    = ovf_q;
          count_d             = '0;
          ovf_d               = 1'b0;
          best_d              = NO_AREA;
          state_d             = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      best_q      <= NO_AREA;
      sv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      best_q      <= best_d;
      sv_q        <= sv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    j_q     <= j_d;
    k_q     <= k_d;
    hit_a_q <= hit_a_d;
    hit_b_q <= hit_b_d;
    p1_q    <= p1_d;
    p2_q    <= p2_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_no_area_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.min_area != NO_AREA))
    else $error("no-rectangle marker leaked to output");

  a_clear_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && state_d == ST_LOAD) |=> (count_q == '0 && !ovf_q && out_valid_o))
    else $error("set state not cleared when result issued");

  a_best_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD && state_q != ST_DONE) |=> (best_q <= $past(best_q)))
    else $error("best area grew during search");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (k_q <= count_q))
    else $error("scan pointer past point count");

endmodule

// ----- sv/mar_area_mul.sv -----
// Registered area unit: |dx| * |dy| of two opposite corners.
// Depends on mar_pkg (point_t, COORD_BITS, AREA_BITS).
module mar_area_mul (
  input  logic                       clk_i,
  input  mar_pkg::point_t            a_i,
  input  mar_pkg::point_t            b_i,
  output logic [mar_pkg::AREA_BITS-1:0] area_o
);
  import mar_pkg::*;

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [AREA_BITS-1:0]  area_q;

  assign dx = (a_i.x > b_i.x) ? (a_i.x - b_i.x) : (b_i.x - a_i.x);
  assign dy = (a_i.y > b_i.y) ? (a_i.y - b_i.y) : (b_i.y - a_i.y);

  always_ff @(posedge clk_i) begin
    area_q <= AREA_BITS'(dx) * AREA_BITS'(dy);
  end

  assign area_o = area_q;

endmodule
